@@ sv/usb_ssd_pkg.sv @@
`default_nettype none

package usb_ssd_pkg;

    // counter width default
    localparam int COUNT_BITS_DEF = 32;

    // packet framing
    localparam int POS_BITS     = 11;
    localparam int STATUS_BYTES = 2;
    localparam logic [POS_BITS-1:0] LINE_STATUS_POS   = POS_BITS'(STATUS_BYTES - 1);
    localparam logic [POS_BITS-1:0] FIRST_PAYLOAD_POS = POS_BITS'(STATUS_BYTES);
    localparam logic [POS_BITS-1:0] MIN_PACKET_SIZE   = POS_BITS'(STATUS_BYTES + 1);
    localparam logic [POS_BITS-1:0] PACKET_SIZE_RESET = POS_BITS'(64);

    // line status bit positions
    localparam int LSR_OVERRUN_BIT = 1;
    localparam int LSR_FRAMING_BIT = 3;
    localparam int LSR_BREAK_BIT   = 4;

    // command codes
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // one input transaction
    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       last_of_transfer;
    } t_item;

endpackage

`default_nettype wire

@@ sv/usb_ssd_if.sv @@
`default_nettype none

// input byte channel
interface usb_ssd_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;
    logic       last_of_transfer;

    modport source (output valid, output command, output data_byte,
                    output last_of_transfer, input ready);
    modport sink   (input valid, input command, input data_byte,
                    input last_of_transfer, output ready);
endinterface

// result channel
interface usb_ssd_out_if #(
    parameter int COUNT_BITS = usb_ssd_pkg::COUNT_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  payload_valid;
    logic [7:0]            payload_byte;
    logic [COUNT_BITS-1:0] overrun_total;
    logic [COUNT_BITS-1:0] framing_total;
    logic [COUNT_BITS-1:0] break_total;
    logic                  break_active;
    logic [COUNT_BITS-1:0] lost_total;

    modport source (output valid, output payload_valid, output payload_byte,
                    output overrun_total, output framing_total, output break_total,
                    output break_active, output lost_total, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input overrun_total, input framing_total, input break_total,
                    input break_active, input lost_total, output ready);
endinterface

`default_nettype wire

@@ sv/usb_ssd_in_reg.sv @@
`default_nettype none

module usb_ssd_in_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    usb_ssd_in_if.sink          i_in,
    input  wire                 i_down_ready,
    output logic                o_valid,
    output usb_ssd_pkg::t_item  o_item
);

    logic               r_valid;
    logic               n_valid;
    usb_ssd_pkg::t_item r_item;
    logic               w_ready;

    // room when empty or when the held transaction moves on
    assign w_ready    = !r_valid || i_down_ready;
    assign i_in.ready = w_ready;

    // occupancy
    always_comb begin
        n_valid = r_valid;
        if (w_ready) begin
            n_valid = i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (w_ready && i_in.valid) begin
            r_item.command          <= i_in.command;
            r_item.data_byte        <= i_in.data_byte;
            r_item.last_of_transfer <= i_in.last_of_transfer;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ sv/usb_ssd_proc.sv @@
`default_nettype none

module usb_ssd_proc #(
    parameter int COUNT_BITS = usb_ssd_pkg::COUNT_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    input  wire usb_ssd_pkg::t_item               i_item,
    output logic                                  o_ready,
    input  wire [usb_ssd_pkg::POS_BITS-1:0]       i_packet_size,
    usb_ssd_out_if.source                         o_out
);

    localparam int PB = usb_ssd_pkg::POS_BITS;

    logic                  r_out_valid, n_out_valid;
    logic                  r_pay_valid, n_pay_valid;
    logic [7:0]            r_pay_byte,  n_pay_byte;
    logic [PB-1:0]         r_pos,       n_pos;
    logic [COUNT_BITS-1:0] r_ovr,       n_ovr;
    logic [COUNT_BITS-1:0] r_frm,       n_frm;
    logic [COUNT_BITS-1:0] r_brk,       n_brk;
    logic                  r_brk_flag,  n_brk_flag;
    logic [COUNT_BITS-1:0] r_loss,      n_loss;

    logic                  w_fire;
    logic [PB-1:0]         w_size;
    logic [PB:0]           w_pos_inc;
    logic                  w_brk_bit;

    // result register frees up when empty or taken
    assign o_ready = !r_out_valid || o_out.ready;
    assign w_fire  = i_valid && o_ready;

    // packet size floor
    assign w_size = (i_packet_size < usb_ssd_pkg::MIN_PACKET_SIZE)
                    ? usb_ssd_pkg::MIN_PACKET_SIZE : i_packet_size;
    assign w_pos_inc = {1'b0, r_pos} + {{PB{1'b0}}, 1'b1};
    assign w_brk_bit = i_item.data_byte[usb_ssd_pkg::LSR_BREAK_BIT];

    // deframe and count
    always_comb begin
        n_out_valid = r_out_valid;
        n_pay_valid = r_pay_valid;
        n_pay_byte  = r_pay_byte;
        n_pos       = r_pos;
        n_ovr       = r_ovr;
        n_frm       = r_frm;
        n_brk       = r_brk;
        n_brk_flag  = r_brk_flag;
        n_loss      = r_loss;
        if (o_ready) begin
            n_out_valid = i_valid;
        end
        if (w_fire) begin
            n_pay_valid = 1'b0;
            n_pay_byte  = 8'd0;
            case (i_item.command)
                usb_ssd_pkg::CMD_CLEAR: begin
                    n_ovr = '0;
                    n_frm = '0;
                end
                usb_ssd_pkg::CMD_BYTE: begin
                    if (r_pos == usb_ssd_pkg::LINE_STATUS_POS) begin
                        if (i_item.data_byte[usb_ssd_pkg::LSR_OVERRUN_BIT]) begin
                            n_ovr  = r_ovr + 1'b1;
                            n_loss = r_loss + 1'b1;
                        end
                        if (i_item.data_byte[usb_ssd_pkg::LSR_FRAMING_BIT]) begin
                            n_frm = r_frm + 1'b1;
                        end
                        // count break on its rising edge only
                        if (w_brk_bit && !r_brk_flag) begin
                            n_brk = r_brk + 1'b1;
                        end
                        n_brk_flag = w_brk_bit;
                    end else if (r_pos >= usb_ssd_pkg::FIRST_PAYLOAD_POS) begin
                        n_pay_valid = 1'b1;
                        n_pay_byte  = i_item.data_byte;
                    end
                    // packet position, restart on end of packet or transfer
                    if (i_item.last_of_transfer || (w_pos_inc >= {1'b0, w_size})) begin
                        n_pos = '0;
                    end else begin
                        n_pos = w_pos_inc[PB-1:0];
                    end
                end
                default: begin
                    n_pos = r_pos;
                end
            endcase
        end
    end

    // control and counter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_ovr       <= '0;
            r_frm       <= '0;
            r_brk       <= '0;
            r_brk_flag  <= 1'b0;
            r_loss      <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            r_ovr       <= n_ovr;
            r_frm       <= n_frm;
            r_brk       <= n_brk;
            r_brk_flag  <= n_brk_flag;
            r_loss      <= n_loss;
        end
    end

    // payload result
    always_ff @(posedge i_clk) begin
        r_pay_valid <= n_pay_valid;
        r_pay_byte  <= n_pay_byte;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.payload_valid = r_pay_valid;
    assign o_out.payload_byte  = r_pay_byte;
    assign o_out.overrun_total = r_ovr;
    assign o_out.framing_total = r_frm;
    assign o_out.break_total   = r_brk;
    assign o_out.break_active  = r_brk_flag;
    assign o_out.lost_total    = r_loss;

endmodule

`default_nettype wire

@@ sv/usb_serial_status_deframer_core.sv @@
// Serial status deframer: strips the two status bytes from each packet of a
// bulk-in transfer, passes the rest on as payload and counts line errors.
// i_in carries one transaction per transfer byte (command 0) or a clear of
// the overrun and framing counters (command 1). o_out carries exactly one
// result per input transaction: the payload byte when there is one, and
// the error counters and break state after that transaction.
// i_cfg_wr_en / i_cfg_wr_data write the packet size; write it only while
// no transaction is in flight.
// A transaction accepted by i_in passes two register stages, the input
// register and then the result register. Throughput: one transaction per
// cycle while o_out is not stalled, set by the combinational update of
// the position and counters between the two registers.
// Reset (synchronous, active low) empties both stages, zeroes all counters
// and the packet position, and sets the packet size to 64.
// When o_out is stalled the result register holds, the input register
// fills behind it, and i_in.ready drops once both are full.
`default_nettype none

module usb_serial_status_deframer_core #(
    parameter int COUNT_BITS = usb_ssd_pkg::COUNT_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    usb_ssd_in_if.sink                         i_in,
    usb_ssd_out_if.source                      o_out,
    input  wire                                i_cfg_wr_en,
    input  wire [usb_ssd_pkg::POS_BITS-1:0]    i_cfg_wr_data
);

    logic [usb_ssd_pkg::POS_BITS-1:0] r_packet_size;
    logic                             w_s1_valid;
    usb_ssd_pkg::t_item               w_s1_item;
    logic                             w_proc_ready;

    // packet size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_size <= usb_ssd_pkg::PACKET_SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            r_packet_size <= i_cfg_wr_data;
        end
    end

    // input register stage
    usb_ssd_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_down_ready (w_proc_ready),
        .o_valid      (w_s1_valid),
        .o_item       (w_s1_item)
    );

    // deframe, count and result register
    usb_ssd_proc #(
        .COUNT_BITS (COUNT_BITS)
    ) u_proc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_s1_valid),
        .i_item        (w_s1_item),
        .o_ready       (w_proc_ready),
        .i_packet_size (r_packet_size),
        .o_out         (o_out)
    );

`ifndef SYNTHESIS
    // a processed clear shows zeroed overrun and framing counts
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_valid && w_proc_ready && (w_s1_item.command == usb_ssd_pkg::CMD_CLEAR))
        |=> (o_out.valid && (o_out.overrun_total == '0) && (o_out.framing_total == '0)))
        else $error("clear transaction did not zero counters");

    // status bytes and clears carry a zero payload
    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.payload_valid) |-> (o_out.payload_byte == 8'd0))
        else $error("nonzero payload byte without payload_valid");

    // input side only stalls while the input register is occupied
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_s1_valid |-> i_in.ready)
        else $error("input stalled with empty input register");

    // both stages empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (!o_out.valid && !w_s1_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
